>>> hdl/serial_eeprom_bitbang_reader_defines.svh
// Assertion macros used by sebr_core.
`ifndef SERIAL_EEPROM_BITBANG_READER_DEFINES_SVH
`define SERIAL_EEPROM_BITBANG_READER_DEFINES_SVH

// Checks that a property holds at every clock edge outside of reset.
`define SEBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a property in the next cycle.
`define SEBR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sebr_pkg.sv
`timescale 1ns / 1ps

package sebr_pkg;

  localparam int unsigned ADDR_W = 7;
  localparam int unsigned CNT_W  = 8;

  localparam logic [CNT_W-1:0] EEPROM_BYTES = 8'd128;
  localparam logic [CNT_W-1:0] COUNT_RESET  = 8'd128;
  localparam logic [7:0]       NACK_VALUE   = 8'hFF;

  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_BYTE_COUNT = 1'b0;

  typedef struct packed {
    logic start_req;
    logic data_in;
  } sebr_item_t;

  typedef struct packed {
    logic              clk_out;
    logic              data_out;
    logic              busy_res;
    logic              byte_valid;
    logic [ADDR_W-1:0] byte_addr;
    logic [7:0]        byte_value;
    logic              addr_acked;
    logic              done_res;
  } sebr_res_t;

endpackage

>>> hdl/sebr_in_if.sv
`timescale 1ns / 1ps

interface sebr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic data_in;

  modport source (output valid, output start_req, output data_in, input ready);
  modport sink (input valid, input start_req, input data_in, output ready);
endinterface

>>> hdl/sebr_out_if.sv
`timescale 1ns / 1ps

interface sebr_out_if;
  logic       valid;
  logic       ready;
  logic       clk_out;
  logic       data_out;
  logic       busy_res;
  logic       byte_valid;
  logic [6:0] byte_addr;
  logic [7:0] byte_value;
  logic       addr_acked;
  logic       done_res;

  modport source (
    output valid, output clk_out, output data_out, output busy_res,
    output byte_valid, output byte_addr, output byte_value,
    output addr_acked, output done_res, input ready
  );
  modport sink (
    input valid, input clk_out, input data_out, input busy_res,
    input byte_valid, input byte_addr, input byte_value,
    input addr_acked, input done_res, output ready
  );
endinterface

>>> hdl/sebr_cfg.sv
`timescale 1ns / 1ps

module sebr_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sebr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic [sebr_pkg::CNT_W-1:0]   byte_count_o
);
  import sebr_pkg::*;

  logic [CNT_W-1:0] byte_count_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BYTE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= COUNT_RESET;
    end else if (wr_en) begin
      byte_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_BYTE_COUNT) begin
      prdata = {{(32 - CNT_W){1'b0}}, byte_count_q};
    end
  end

  assign byte_count_o = byte_count_q;
endmodule

>>> hdl/sebr_core.sv
`timescale 1ns / 1ps
`include "serial_eeprom_bitbang_reader_defines.svh"

module sebr_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sebr_pkg::CNT_W-1:0] byte_count_i,
  sebr_in_if.sink                    in_ch_i,
  sebr_out_if.source                 out_ch_o
);
  import sebr_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_DH, PH_ST_CH, PH_ST_DL, PH_ST_CL,
    PH_AB_SET, PH_AB_CH, PH_AB_CL,
    PH_A1_DH, PH_A1_CH, PH_A1_SAMP, PH_A1_REL,
    PH_RD_DH, PH_RD_CH, PH_RD_SAMP, PH_RD_DL,
    PH_A2_DH, PH_A2_CH, PH_A2_SAMP, PH_A2_REL
  } phase_e;

  logic             in_valid_q;
  sebr_item_t       in_q;
  logic             out_valid_q;
  sebr_res_t        out_q;
  logic             advance;

  phase_e           phase_q, phase_d;
  logic [2:0]       bit_q, bit_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]       shift_q, shift_d;
  logic             clk_line_q, clk_line_d;
  logic             data_line_q, data_line_d;
  logic             ack_q, ack_d;

  logic [CNT_W-1:0] eff_count;
  logic             last;
  logic             fin;
  logic [7:0]       fin_value;
  logic             fin_acked;
  logic             busy;
  sebr_res_t        res_d;

  assign advance       = in_valid_q && (!out_valid_q || out_ch_o.ready);
  assign in_ch_i.ready = !in_valid_q || advance;

  always_comb begin
    eff_count = byte_count_i;
    if (byte_count_i == '0) begin
      eff_count = {{(CNT_W - 1){1'b0}}, 1'b1};
    end else if (byte_count_i > EEPROM_BYTES) begin
      eff_count = EEPROM_BYTES;
    end
  end

  assign last = ({1'b0, addr_q} + {{(CNT_W - 1){1'b0}}, 1'b1}) >= eff_count;

  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    addr_d      = addr_q;
    shift_d     = shift_q;
    clk_line_d  = clk_line_q;
    data_line_d = data_line_q;
    ack_d       = ack_q;
    busy        = 1'b1;
    fin         = 1'b0;
    fin_value   = NACK_VALUE;
    fin_acked   = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (in_q.start_req) begin
          clk_line_d  = 1'b1;
          data_line_d = 1'b1;
          addr_d      = '0;
          phase_d     = PH_ST_DH;
        end else begin
          busy = 1'b0;
        end
      end
      PH_ST_DH: begin
        data_line_d = 1'b1;
        phase_d     = PH_ST_CH;
      end
      PH_ST_CH: begin
        clk_line_d = 1'b1;
        phase_d    = PH_ST_DL;
      end
      PH_ST_DL: begin
        data_line_d = 1'b0;
        phase_d     = PH_ST_CL;
      end
      PH_ST_CL: begin
        clk_line_d = 1'b0;
        bit_d      = 3'd7;
        shift_d    = {addr_q, 1'b1};
        phase_d    = PH_AB_SET;
      end
      PH_AB_SET: begin
        data_line_d = shift_q[bit_q];
        phase_d     = PH_AB_CH;
      end
      PH_AB_CH: begin
        clk_line_d = 1'b1;
        phase_d    = PH_AB_CL;
      end
      PH_AB_CL: begin
        clk_line_d = 1'b0;
        if (bit_q == 3'd0) begin
          phase_d = PH_A1_DH;
        end else begin
          bit_d   = bit_q - 3'd1;
          phase_d = PH_AB_SET;
        end
      end
      PH_A1_DH: begin
        data_line_d = 1'b1;
        phase_d     = PH_A1_CH;
      end
      PH_A1_CH: begin
        clk_line_d = 1'b1;
        phase_d    = PH_A1_SAMP;
      end
      PH_A1_SAMP: begin
        ack_d       = !in_q.data_in;
        data_line_d = in_q.data_in;
        clk_line_d  = 1'b0;
        phase_d     = PH_A1_REL;
      end
      PH_A1_REL: begin
        data_line_d = 1'b1;
        if (ack_q) begin
          bit_d   = '0;
          shift_d = '0;
          phase_d = PH_RD_DH;
        end else begin
          fin       = 1'b1;
          fin_value = NACK_VALUE;
          fin_acked = 1'b0;
        end
      end
      PH_RD_DH: begin
        data_line_d = 1'b1;
        phase_d     = PH_RD_CH;
      end
      PH_RD_CH: begin
        clk_line_d = 1'b1;
        phase_d    = PH_RD_SAMP;
      end
      PH_RD_SAMP: begin
        shift_d    = {shift_q[6:0], in_q.data_in};
        clk_line_d = 1'b0;
        phase_d    = PH_RD_DL;
      end
      PH_RD_DL: begin
        data_line_d = 1'b0;
        if (bit_q == 3'd7) begin
          phase_d = PH_A2_DH;
        end else begin
          bit_d   = bit_q + 3'd1;
          phase_d = PH_RD_DH;
        end
      end
      PH_A2_DH: begin
        data_line_d = 1'b1;
        phase_d     = PH_A2_CH;
      end
      PH_A2_CH: begin
        clk_line_d = 1'b1;
        phase_d    = PH_A2_SAMP;
      end
      PH_A2_SAMP: begin
        data_line_d = in_q.data_in;
        clk_line_d  = 1'b0;
        phase_d     = PH_A2_REL;
      end
      PH_A2_REL: begin
        data_line_d = 1'b1;
        fin         = 1'b1;
        fin_value   = shift_q;
        fin_acked   = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
        busy    = 1'b0;
      end
    endcase

    res_d = '0;
    if (fin) begin
      res_d.byte_valid = 1'b1;
      res_d.byte_addr  = addr_q;
      res_d.byte_value = fin_value;
      res_d.addr_acked = fin_acked;
      res_d.done_res   = last;
      if (last) begin
        phase_d = PH_IDLE;
        addr_d  = '0;
      end else begin
        addr_d  = addr_q + {{(ADDR_W - 1){1'b0}}, 1'b1};
        phase_d = PH_ST_DH;
      end
    end
    res_d.clk_out  = clk_line_d;
    res_d.data_out = data_line_d;
    res_d.busy_res = busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      addr_q      <= '0;
      shift_q     <= '0;
      clk_line_q  <= 1'b1;
      data_line_q <= 1'b1;
      ack_q       <= 1'b0;
    end else begin
      if (in_ch_i.ready) begin
        in_valid_q <= in_ch_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        bit_q       <= bit_d;
        addr_q      <= addr_d;
        shift_q     <= shift_d;
        clk_line_q  <= clk_line_d;
        data_line_q <= data_line_d;
        ack_q       <= ack_d;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch_i.ready && in_ch_i.valid) begin
      in_q.start_req <= in_ch_i.start_req;
      in_q.data_in   <= in_ch_i.data_in;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.clk_out    = out_q.clk_out;
  assign out_ch_o.data_out   = out_q.data_out;
  assign out_ch_o.busy_res   = out_q.busy_res;
  assign out_ch_o.byte_valid = out_q.byte_valid;
  assign out_ch_o.byte_addr  = out_q.byte_addr;
  assign out_ch_o.byte_value = out_q.byte_value;
  assign out_ch_o.addr_acked = out_q.addr_acked;
  assign out_ch_o.done_res   = out_q.done_res;

  `SEBR_ASSERT(a_byte_in_pass, !(out_valid_q && out_q.byte_valid) || out_q.busy_res, "byte outside a pass")
  `SEBR_ASSERT(a_done_with_byte, !(out_valid_q && out_q.done_res) || out_q.byte_valid, "done without a byte")
  `SEBR_ASSERT_NEXT(a_done_to_idle, advance && fin && last, phase_q == PH_IDLE && addr_q == '0, "pass did not end")
  `SEBR_ASSERT_NEXT(a_item_held, in_valid_q && !advance, in_valid_q, "pending item lost")
endmodule

>>> hdl/serial_eeprom_bitbang_reader.sv
`timescale 1ns / 1ps
// Pipeline: each item is held in the input register, and its result in the result
// register, which loads only when the line sequencer advances.
// Throughput: one item per cycle unless the output stalls; each is one state transition.
// Reset: the sequencer goes idle with both lines released high and byte_count set to 128.
module serial_eeprom_bitbang_reader (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sebr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  sebr_in_if.sink                      in_ch_i,
  sebr_out_if.source                   out_ch_o
);
  import sebr_pkg::*;

  logic [CNT_W-1:0] byte_count;

  sebr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .byte_count_o (byte_count)
  );

  sebr_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_count_i (byte_count),
    .in_ch_i      (in_ch_i),
    .out_ch_o     (out_ch_o)
  );
endmodule
